// ===== hdl/lcd_window_pixel_command_stream_defines.svh =====
// assertion macros used by lwp_back
`ifndef LCD_WINDOW_PIXEL_COMMAND_STREAM_DEFINES_SVH
`define LCD_WINDOW_PIXEL_COMMAND_STREAM_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define LWP_ASSERT_IMPL(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("implication check failed");
`define LWP_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("next-cycle check failed");
`else
`define LWP_ASSERT_IMPL(label, clk, rst_n, cond, expr)
`define LWP_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif

`endif

// ===== hdl/lwp_pkg.sv =====
package lwp_pkg;

    localparam int COORD_IN_W   = 9;
    localparam int COORD_W      = 10;
    localparam int COLOR_W      = 16;
    localparam int BYTE_W       = 8;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;
    localparam int QUEUE_DEPTH  = 2;
    localparam int STEP_W       = 4;

    localparam logic [BYTE_W-1:0] CMD_COLUMN_SET = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_ROW_SET    = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_MEM_WRITE  = 8'h2C;
    localparam logic [7:0]        OFFSET_RESET   = 8'd34;

    localparam logic [CFG_INDEX_W-1:0] CFG_ORIENTATION = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OFFSET      = 2'd1;

    typedef enum logic [1:0] {
        OP_WINDOW = 2'd0,
        OP_POINT  = 2'd1,
        OP_PIXEL  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // byte positions of the longest run
    localparam logic [STEP_W-1:0] STEP_COL_CMD  = 4'd0;
    localparam logic [STEP_W-1:0] STEP_C1_HI    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_C1_LO    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_C2_HI    = 4'd3;
    localparam logic [STEP_W-1:0] STEP_C2_LO    = 4'd4;
    localparam logic [STEP_W-1:0] STEP_ROW_CMD  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_R1_HI    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_R1_LO    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_R2_HI    = 4'd8;
    localparam logic [STEP_W-1:0] STEP_R2_LO    = 4'd9;
    localparam logic [STEP_W-1:0] STEP_MEM_CMD  = 4'd10;
    localparam logic [STEP_W-1:0] STEP_COLOR_LO = 4'd11;
    localparam logic [STEP_W-1:0] STEP_COLOR_HI = 4'd12;

    typedef struct packed {
        t_op                 kind;
        logic [COORD_W-1:0]  c1;
        logic [COORD_W-1:0]  c2;
        logic [COORD_W-1:0]  r1;
        logic [COORD_W-1:0]  r2;
        logic [COLOR_W-1:0]  color;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

    function automatic logic [BYTE_W-1:0] coord_hi(input logic [COORD_W-1:0] v);
        coord_hi = BYTE_W'(v >> 8);
    endfunction

endpackage

// ===== hdl/lcd_window_pixel_command_stream.sv =====
// path: a request goes through the queue, the sequencer's command register and the
// output register; one byte per cycle while a request runs and the output does not stall,
// and the sequencer loads the next request from the queue only while it is idle; the byte
// sequencer in the back end sets the rate, the queue lets input run ahead by its depth
// reset: synchronous active low; clears queue, sequencer and output valid,
// orientation to 0 and panel offset to 34
module lcd_window_pixel_command_stream #(
    parameter int QUEUE_DEPTH = lwp_pkg::QUEUE_DEPTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic [1:0]                         i_operation,
    input  logic [lwp_pkg::COORD_IN_W-1:0]     i_col_start,
    input  logic [lwp_pkg::COORD_IN_W-1:0]     i_row_start,
    input  logic [lwp_pkg::COORD_IN_W-1:0]     i_col_end,
    input  logic [lwp_pkg::COORD_IN_W-1:0]     i_row_end,
    input  logic [lwp_pkg::COLOR_W-1:0]        i_pixel_color,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic [lwp_pkg::BYTE_W-1:0]         o_spi_byte,
    output logic                               o_is_data,
    output logic                               o_last_of_run,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lwp_pkg::CFG_INDEX_W-1:0]    i_cfg_index,
    input  logic [lwp_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    logic               w_push, w_pop;
    lwp_pkg::t_cmd      w_cmd_in, w_cmd_out;
    lwp_pkg::t_q_status w_q_status;

    lwp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_col_start   (i_col_start),
        .i_row_start   (i_row_start),
        .i_col_end     (i_col_end),
        .i_row_end     (i_row_end),
        .i_pixel_color (i_pixel_color),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_status    (w_q_status),
        .o_push        (w_push),
        .o_cmd         (w_cmd_in)
    );

    lwp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_cmd_in),
        .i_pop    (w_pop),
        .o_data   (w_cmd_out),
        .o_status (w_q_status)
    );

    lwp_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd_out),
        .i_q_status    (w_q_status),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_spi_byte    (o_spi_byte),
        .o_is_data     (o_is_data),
        .o_last_of_run (o_last_of_run)
    );

endmodule

// ===== hdl/lwp_queue.sv =====
module lwp_queue #(
    parameter int DEPTH = lwp_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  lwp_pkg::t_cmd     i_data,
    input  logic              i_pop,
    output lwp_pkg::t_cmd     o_data,
    output lwp_pkg::t_q_status o_status
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    lwp_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             w_push, w_pop;

    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/lwp_front.sv =====
module lwp_front (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [1:0]                           i_operation,
    input  logic [lwp_pkg::COORD_IN_W-1:0]       i_col_start,
    input  logic [lwp_pkg::COORD_IN_W-1:0]       i_row_start,
    input  logic [lwp_pkg::COORD_IN_W-1:0]       i_col_end,
    input  logic [lwp_pkg::COORD_IN_W-1:0]       i_row_end,
    input  logic [lwp_pkg::COLOR_W-1:0]          i_pixel_color,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [lwp_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [lwp_pkg::CFG_DATA_W-1:0]       i_cfg_data,
    input  lwp_pkg::t_q_status                   i_q_status,
    output logic                                 o_push,
    output lwp_pkg::t_cmd                        o_cmd
);
    logic [1:0]                      r_orientation;
    logic [7:0]                      r_panel_offset;
    lwp_pkg::t_op                    w_op;
    logic [lwp_pkg::COORD_W-1:0]     w_col_add, w_row_add;
    logic [lwp_pkg::COORD_IN_W-1:0]  w_ce_src, w_re_src;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = i_q_status.full;
    assign w_op        = lwp_pkg::t_op'(i_operation);

    // orientations 0,1 shift columns, 2,3 shift rows
    assign w_col_add = r_orientation[1] ? '0 : lwp_pkg::COORD_W'(r_panel_offset);
    assign w_row_add = r_orientation[1] ? lwp_pkg::COORD_W'(r_panel_offset) : '0;

    // a point is a one-pixel window
    assign w_ce_src = (w_op == lwp_pkg::OP_POINT) ? i_col_start : i_col_end;
    assign w_re_src = (w_op == lwp_pkg::OP_POINT) ? i_row_start : i_row_end;

    always_comb begin
        o_cmd.kind  = w_op;
        o_cmd.c1    = lwp_pkg::COORD_W'(i_col_start) + w_col_add;
        o_cmd.c2    = lwp_pkg::COORD_W'(w_ce_src) + w_col_add;
        o_cmd.r1    = lwp_pkg::COORD_W'(i_row_start) + w_row_add;
        o_cmd.r2    = lwp_pkg::COORD_W'(w_re_src) + w_row_add;
        o_cmd.color = i_pixel_color;
    end

    // unused op code is taken and dropped
    assign o_push = i_in_valid && !o_in_stall && (w_op != lwp_pkg::OP_NONE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orientation  <= 2'd0;
            r_panel_offset <= lwp_pkg::OFFSET_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == lwp_pkg::CFG_ORIENTATION) begin
                r_orientation <= i_cfg_data[1:0];
            end else if (i_cfg_index == lwp_pkg::CFG_OFFSET) begin
                r_panel_offset <= i_cfg_data[7:0];
            end
        end
    end

endmodule

// ===== hdl/lwp_back.sv =====
`include "lcd_window_pixel_command_stream_defines.svh"

module lwp_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lwp_pkg::t_cmd                 i_cmd,
    input  lwp_pkg::t_q_status            i_q_status,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [lwp_pkg::BYTE_W-1:0]    o_spi_byte,
    output logic                          o_is_data,
    output logic                          o_last_of_run
);
    lwp_pkg::t_cmd                 r_cmd;
    logic                          r_busy;
    logic [lwp_pkg::STEP_W-1:0]    r_step;
    logic                          r_out_valid;
    logic [lwp_pkg::BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic                          r_out_data, n_out_data;
    logic                          r_out_last;
    logic                          w_adv;
    logic                          w_at_last;
    logic [lwp_pkg::STEP_W-1:0]    w_last_step;

    assign o_pop = !r_busy && !i_q_status.empty;
    // output slot is free or being drained this cycle
    assign w_adv = r_busy && (!r_out_valid || !i_out_stall);

    assign w_last_step = (r_cmd.kind == lwp_pkg::OP_WINDOW) ? lwp_pkg::STEP_MEM_CMD
                                                            : lwp_pkg::STEP_COLOR_HI;
    assign w_at_last = (r_step == w_last_step);

    always_comb begin
        n_out_data = 1'b1;
        case (r_step)
            lwp_pkg::STEP_COL_CMD: begin
                n_out_byte = lwp_pkg::CMD_COLUMN_SET;
                n_out_data = 1'b0;
            end
            lwp_pkg::STEP_C1_HI:    n_out_byte = lwp_pkg::coord_hi(r_cmd.c1);
            lwp_pkg::STEP_C1_LO:    n_out_byte = r_cmd.c1[7:0];
            lwp_pkg::STEP_C2_HI:    n_out_byte = lwp_pkg::coord_hi(r_cmd.c2);
            lwp_pkg::STEP_C2_LO:    n_out_byte = r_cmd.c2[7:0];
            lwp_pkg::STEP_ROW_CMD: begin
                n_out_byte = lwp_pkg::CMD_ROW_SET;
                n_out_data = 1'b0;
            end
            lwp_pkg::STEP_R1_HI:    n_out_byte = lwp_pkg::coord_hi(r_cmd.r1);
            lwp_pkg::STEP_R1_LO:    n_out_byte = r_cmd.r1[7:0];
            lwp_pkg::STEP_R2_HI:    n_out_byte = lwp_pkg::coord_hi(r_cmd.r2);
            lwp_pkg::STEP_R2_LO:    n_out_byte = r_cmd.r2[7:0];
            lwp_pkg::STEP_MEM_CMD: begin
                n_out_byte = lwp_pkg::CMD_MEM_WRITE;
                n_out_data = 1'b0;
            end
            lwp_pkg::STEP_COLOR_LO: n_out_byte = r_cmd.color[7:0];
            lwp_pkg::STEP_COLOR_HI: n_out_byte = r_cmd.color[15:8];
            default:                n_out_byte = r_cmd.color[15:8];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= lwp_pkg::STEP_COL_CMD;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_busy <= 1'b1;
                r_step <= (i_cmd.kind == lwp_pkg::OP_PIXEL) ? lwp_pkg::STEP_COLOR_LO
                                                           : lwp_pkg::STEP_COL_CMD;
            end else if (w_adv) begin
                r_step <= r_step + 1'b1;
                if (w_at_last) begin
                    r_busy <= 1'b0;
                end
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        if (w_adv) begin
            r_out_byte <= n_out_byte;
            r_out_data <= n_out_data;
            r_out_last <= w_at_last;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_spi_byte    = r_out_byte;
    assign o_is_data     = r_out_data;
    assign o_last_of_run = r_out_last;

    `LWP_ASSERT_IMPL(a_cmd_byte_code, i_clk, i_rst_n, r_out_valid && !r_out_data, r_out_byte == lwp_pkg::CMD_COLUMN_SET || r_out_byte == lwp_pkg::CMD_ROW_SET || r_out_byte == lwp_pkg::CMD_MEM_WRITE)
    `LWP_ASSERT_IMPL(a_last_cmd_is_memwr, i_clk, i_rst_n, r_out_valid && r_out_last && !r_out_data, r_out_byte == lwp_pkg::CMD_MEM_WRITE)
    `LWP_ASSERT_IMPL(a_pixel_color_only, i_clk, i_rst_n, r_busy && r_cmd.kind == lwp_pkg::OP_PIXEL, r_step == lwp_pkg::STEP_COLOR_LO || r_step == lwp_pkg::STEP_COLOR_HI)
    `LWP_ASSERT_NEXT(a_done_after_last, i_clk, i_rst_n, w_adv && w_at_last, !r_busy && r_out_last)

endmodule

// ===== tb/sv/lcd_window_pixel_command_stream_tb.sv =====
module lcd_window_pixel_command_stream_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  PHASE_ITEMS  = 35;
    localparam int  LONG_HOLD    = 300;
    localparam int  IDLE_SETTLE  = 40;
    localparam logic [lwp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [lwp_pkg::CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;

    typedef struct packed {
        logic [lwp_pkg::BYTE_W-1:0] value;
        logic                       is_data;
        logic                       last;
    } t_lcd_word;

    class lcd_byte_scoreboard;
        t_lcd_word        expected_bytes[$];
        logic [1:0]       orient;
        logic [7:0]       offset;
        int               errors;
        int               checked;
        int               op_seen[4];

        function new();
            orient  = 2'd0;
            offset  = lwp_pkg::OFFSET_RESET;
            errors  = 0;
            checked = 0;
            foreach (op_seen[k]) op_seen[k] = 0;
        endfunction

        function void write_reg(logic [lwp_pkg::CFG_INDEX_W-1:0] idx,
                                logic [lwp_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                lwp_pkg::CFG_ORIENTATION: orient = data[1:0];
                lwp_pkg::CFG_OFFSET:      offset = data;
                default: ;
            endcase
        endfunction

        task report(string msg);
            errors++;
            $display("mismatch at %0t: %s", $time, msg);
        endtask

        function void push_byte(logic [7:0] b, logic d);
            t_lcd_word w;
            w.value   = b;
            w.is_data = d;
            w.last    = 1'b0;
            expected_bytes.push_back(w);
        endfunction

        function void push_coord(logic [15:0] v);
            push_byte(v[15:8], 1'b1);
            push_byte(v[7:0], 1'b1);
        endfunction

        function void push_color(logic [15:0] c);
            push_byte(c[7:0], 1'b1);
            push_byte(c[15:8], 1'b1);
        endfunction

        // offset goes on columns for orientations 0 and 1, on rows otherwise
        function void push_window(logic [8:0] c1, logic [8:0] r1, logic [8:0] c2,
                                  logic [8:0] r2);
            logic [15:0] col_add;
            logic [15:0] row_add;
            col_add = (orient < 2'd2) ? {8'd0, offset} : 16'd0;
            row_add = (orient < 2'd2) ? 16'd0 : {8'd0, offset};
            push_byte(lwp_pkg::CMD_COLUMN_SET, 1'b0);
            push_coord({7'd0, c1} + col_add);
            push_coord({7'd0, c2} + col_add);
            push_byte(lwp_pkg::CMD_ROW_SET, 1'b0);
            push_coord({7'd0, r1} + row_add);
            push_coord({7'd0, r2} + row_add);
            push_byte(lwp_pkg::CMD_MEM_WRITE, 1'b0);
        endfunction

        function void note_input(lwp_pkg::t_op op, logic [8:0] cs, logic [8:0] rs,
                                 logic [8:0] ce, logic [8:0] re, logic [15:0] color);
            int        start_n;
            t_lcd_word tail;
            start_n = expected_bytes.size();
            op_seen[op]++;
            case (op)
                lwp_pkg::OP_WINDOW: push_window(cs, rs, ce, re);
                lwp_pkg::OP_POINT: begin
                    push_window(cs, rs, cs, rs);
                    push_color(color);
                end
                lwp_pkg::OP_PIXEL: push_color(color);
                default: ;
            endcase
            if (expected_bytes.size() > start_n) begin
                tail = expected_bytes.pop_back();
                tail.last = 1'b1;
                expected_bytes.push_back(tail);
            end
        endfunction

        task check_result(logic [7:0] b, logic d, logic l);
            t_lcd_word want;
            checked++;
            if (expected_bytes.size() == 0) begin
                report($sformatf("byte %02h (data %0b last %0b) with nothing expected", b, d, l));
                return;
            end
            want = expected_bytes.pop_front();
            if (b !== want.value)
                report($sformatf("spi_byte %02h, expected %02h", b, want.value));
            if (d !== want.is_data)
                report($sformatf("is_data %0b on byte %02h, expected %0b", d, b, want.is_data));
            if (l !== want.last)
                report($sformatf("last_of_run %0b on byte %02h, expected %0b", l, b, want.last));
        endtask

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                                i_clk = 1'b0;
    logic                                i_rst_n = 1'b0;
    logic                                i_in_valid = 1'b0;
    logic [1:0]                          i_operation = 2'd0;
    logic [lwp_pkg::COORD_IN_W-1:0]      i_col_start = '0;
    logic [lwp_pkg::COORD_IN_W-1:0]      i_row_start = '0;
    logic [lwp_pkg::COORD_IN_W-1:0]      i_col_end = '0;
    logic [lwp_pkg::COORD_IN_W-1:0]      i_row_end = '0;
    logic [lwp_pkg::COLOR_W-1:0]         i_pixel_color = '0;
    logic                                i_out_stall = 1'b0;
    logic                                i_cfg_valid = 1'b0;
    logic [lwp_pkg::CFG_INDEX_W-1:0]     i_cfg_index = '0;
    logic [lwp_pkg::CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic                                o_in_stall;
    logic                                o_out_valid;
    logic [lwp_pkg::BYTE_W-1:0]          o_spi_byte;
    logic                                o_is_data;
    logic                                o_last_of_run;
    logic                                o_cfg_ready;

    lcd_byte_scoreboard sb = new();
    bit long_hold_req = 1'b0;
    int holds_done = 0;
    int stall_cyc = 0;
    int cfg_writes = 0;
    int settings_used = 0;

    lcd_window_pixel_command_stream uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_operation   (i_operation),
        .i_col_start   (i_col_start),
        .i_row_start   (i_row_start),
        .i_col_end     (i_col_end),
        .i_row_end     (i_row_end),
        .i_pixel_color (i_pixel_color),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_spi_byte    (o_spi_byte),
        .o_is_data     (o_is_data),
        .o_last_of_run (o_last_of_run),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_result(o_spi_byte, o_is_data, o_last_of_run);
    end

    // receiver: a long hold on request, otherwise stall patterns taken in turn
    always @(posedge i_clk) begin
        if (long_hold_req) begin
            long_hold_req <= 1'b0;
            holds_done++;
            for (int k = 0; k < LONG_HOLD; k++) begin
                i_out_stall <= 1'b1;
                @(posedge i_clk);
            end
        end
        stall_cyc++;
        case ((stall_cyc / 80) % 4)
            0:       i_out_stall <= 1'b0;
            1:       i_out_stall <= ($urandom_range(0, 99) < 30);
            2:       i_out_stall <= ((stall_cyc % 3) == 0);
            default: i_out_stall <= ($urandom_range(0, 99) < 70);
        endcase
    end

    function automatic logic [8:0] pick_coord();
        case ($urandom_range(0, 9))
            0:       return 9'd0;
            1:       return 9'd319;
            2:       return 9'd511;
            3, 4, 5: return 9'($urandom_range(0, 511));
            default: return 9'($urandom_range(0, 319));
        endcase
    endfunction

    function automatic lwp_pkg::t_op pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return lwp_pkg::OP_WINDOW;
        if (r < 70) return lwp_pkg::OP_POINT;
        if (r < 95) return lwp_pkg::OP_PIXEL;
        return lwp_pkg::OP_NONE;
    endfunction

    task automatic send_word(lwp_pkg::t_op op, logic [8:0] cs, logic [8:0] rs,
                             logic [8:0] ce, logic [8:0] re, logic [15:0] color);
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_col_start   <= cs;
        i_row_start   <= rs;
        i_col_end     <= ce;
        i_row_end     <= re;
        i_pixel_color <= color;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_input(op, cs, rs, ce, re, color);
    endtask

    task automatic send_burst(int n);
        for (int k = 0; k < n; k++)
            send_word(pick_op(), pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                      16'($urandom()));
        i_in_valid <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge i_clk);
    endtask

    // unused operation codes add no expected bytes and are dropped at the input
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_SETTLE) @(posedge i_clk);
    endtask

    task automatic cfg_word(logic [lwp_pkg::CFG_INDEX_W-1:0] idx,
                            logic [lwp_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.write_reg(idx, data);
        cfg_writes++;
    endtask

    task automatic write_regs(logic [1:0] orient, logic [7:0] offset);
        // upper orientation bits are don't-care
        cfg_word(lwp_pkg::CFG_ORIENTATION, {6'($urandom_range(0, 63)), orient});
        cfg_word(lwp_pkg::CFG_OFFSET, offset);
        if ($urandom_range(0, 1)) cfg_word(CFG_SPARE_LO, 8'($urandom()));
        if ($urandom_range(0, 1)) cfg_word(CFG_SPARE_HI, 8'($urandom()));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [1:0] orient_set[6];
        logic [7:0] offset_set[6];
        int         sent;
        int         n;

        orient_set = '{2'd3, 2'd1, 2'd2, 2'd0, 2'd2, 2'd1};
        offset_set = '{8'd255, 8'd0, 8'd170, 8'd255, 8'd0, 8'($urandom_range(1, 254))};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settings_used = 1;

        // directed words under the reset settings
        send_word(lwp_pkg::OP_WINDOW, 9'd0, 9'd0, 9'd319, 9'd319, 16'h0000);
        send_word(lwp_pkg::OP_WINDOW, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
        send_word(lwp_pkg::OP_WINDOW, 9'd319, 9'd200, 9'd0, 9'd1, 16'h1234);
        send_word(lwp_pkg::OP_WINDOW, 9'h155, 9'h0AA, 9'h0AA, 9'h155, 16'hFFFF);
        send_word(lwp_pkg::OP_POINT, 9'd0, 9'd0, 9'd511, 9'd511, 16'h0000);
        send_word(lwp_pkg::OP_POINT, 9'd511, 9'd511, 9'd0, 9'd0, 16'hFFFF);
        send_word(lwp_pkg::OP_POINT, 9'd319, 9'd0, 9'h155, 9'h0AA, 16'hA5C3);
        send_word(lwp_pkg::OP_POINT, 9'h0AA, 9'h155, 9'd319, 9'd319, 16'h5A3C);
        send_word(lwp_pkg::OP_PIXEL, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000);
        send_word(lwp_pkg::OP_PIXEL, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
        send_word(lwp_pkg::OP_PIXEL, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  16'h00FF);
        send_word(lwp_pkg::OP_PIXEL, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  16'hFF00);
        send_word(lwp_pkg::OP_NONE, 9'd511, 9'd511, 9'd511, 9'd511, 16'hFFFF);
        send_word(lwp_pkg::OP_NONE, pick_coord(), pick_coord(), pick_coord(), pick_coord(),
                  16'($urandom()));
        send_word(lwp_pkg::OP_PIXEL, 9'd7, 9'd9, 9'd11, 9'd13, 16'h1234);
        send_word(lwp_pkg::OP_NONE, 9'd0, 9'd0, 9'd0, 9'd0, 16'h0000);
        send_word(lwp_pkg::OP_POINT, 9'd160, 9'd120, 9'd0, 9'd0, 16'h8001);
        drain();

        for (int p = 0; p < 6; p++) begin
            write_regs(orient_set[p], offset_set[p]);
            if (p == 2) begin
                long_hold_req <= 1'b1;
                send_burst(12);
                sent = 12;
            end else begin
                sent = 0;
            end
            while (sent < PHASE_ITEMS) begin
                n = $urandom_range(1, 12);
                if (n > PHASE_ITEMS - sent) n = PHASE_ITEMS - sent;
                send_burst(n);
                sent += n;
            end
            drain();
        end

        $display("covered %0d requests: %0d window, %0d point, %0d pixel, %0d unused code",
                 sb.op_seen[0] + sb.op_seen[1] + sb.op_seen[2] + sb.op_seen[3],
                 sb.op_seen[lwp_pkg::OP_WINDOW], sb.op_seen[lwp_pkg::OP_POINT],
                 sb.op_seen[lwp_pkg::OP_PIXEL], sb.op_seen[lwp_pkg::OP_NONE]);
        $display("%0d bytes checked, %0d register writes over %0d settings, %0d long holds",
                 sb.checked, cfg_writes, settings_used, holds_done);
        if (sb.errors == 0)
            $display("** lcd_window_pixel_command_stream: PASSED **");
        else
            $display("** lcd_window_pixel_command_stream: FAILED **");
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout, %0d bytes still expected", sb.pending());
        $display("** lcd_window_pixel_command_stream: FAILED **");
        $finish;
    end

endmodule
